// File: rtl/core/smtk_pkg.sv
// ----------------------------------------------------------------------------
// smtk_pkg: shared types and constants for the sorted multiset top-k sum
// Beat payloads, status and kind codes, register map and cell control.
// ----------------------------------------------------------------------------
package smtk_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int TAG_BITS_DEF   = 20;

	localparam int VALUE_FIELD_W = 32;
	localparam int TAG_FIELD_W   = 20;
	localparam int SUM_W         = 42;
	localparam int TOPC_W        = 11;
	localparam int STATUS_W      = 2;

	localparam int GRP_SIZE = 32;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = APB_AW - 2;

	localparam logic [REG_IDX_W-1:0] REG_TOP_COUNT = REG_IDX_W'(0);
	localparam logic [TOPC_W-1:0]    TOP_COUNT_RST = TOPC_W'(1);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_ERASE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic                     kind;
		logic [VALUE_FIELD_W-1:0] entry_value;
		logic [TAG_FIELD_W-1:0]   entry_tag;
	} smtk_cmd_t;

	typedef struct packed {
		logic [SUM_W-1:0]    top_sum;
		logic [TOPC_W-1:0]   entry_count;
		logic [STATUS_W-1:0] status;
	} smtk_result_t;

	typedef struct packed {
		logic load_ins;
		logic load_ers;
	} smtk_cell_ctl_t;

endpackage

// File: rtl/core/smtk_cell.sv
// ----------------------------------------------------------------------------
// smtk_cell: one slot of the sorted entry chain
// Holds one entry, compares it with the broadcast operand and takes the
// operand or a neighbor's entry on an insert or erase shift.
// ----------------------------------------------------------------------------
module smtk_cell #(
	parameter int          VALUE_BITS = smtk_pkg::VALUE_BITS_DEF,
	parameter int          TAG_BITS   = smtk_pkg::TAG_BITS_DEF,
	parameter int          CMP_W      = smtk_pkg::TOPC_W,
	parameter int unsigned IDX        = 0
) (
	input  logic                    clk,
	input  smtk_pkg::smtk_cell_ctl_t ctl,
	input  logic [VALUE_BITS-1:0]   op_value,
	input  logic [TAG_BITS-1:0]     op_tag,
	input  logic [CMP_W-1:0]        count,
	input  logic [CMP_W-1:0]        probe,
	input  logic [VALUE_BITS-1:0]   left_value,
	input  logic [TAG_BITS-1:0]     left_tag,
	input  logic                    left_gt,
	input  logic [VALUE_BITS-1:0]   right_value,
	input  logic [TAG_BITS-1:0]     right_tag,
	output logic [VALUE_BITS-1:0]   value,
	output logic [TAG_BITS-1:0]     tag,
	output logic                    gt,
	output logic                    eq,
	output logic [VALUE_BITS-1:0]   probe_value
);
	import smtk_pkg::*;

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic [VALUE_BITS-1:0] value_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic                  occ;

	assign occ         = MY_IDX < count;
	assign gt          = occ && ({value_q, tag_q} > {op_value, op_tag});
	assign eq          = occ && ({value_q, tag_q} == {op_value, op_tag});
	assign probe_value = (probe == MY_IDX) ? value_q : '0;
	assign value       = value_q;
	assign tag         = tag_q;

	always_ff @(posedge clk) begin
		if (ctl.load_ins && !gt) begin
			if (left_gt) begin
				value_q <= op_value;
				tag_q   <= op_tag;
			end else begin
				value_q <= left_value;
				tag_q   <= left_tag;
			end
		end else if (ctl.load_ers && !gt) begin
			value_q <= right_value;
			tag_q   <= right_tag;
		end
	end

endmodule

// File: rtl/core/smtk_probe_tree.sv
// ----------------------------------------------------------------------------
// smtk_probe_tree: two-stage registered OR tree over the cell chain
// Returns the value of the one probed cell and whether any cell matches.
// ----------------------------------------------------------------------------
module smtk_probe_tree #(
	parameter int N = smtk_pkg::CAPACITY_DEF,
	parameter int W = smtk_pkg::VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic [W-1:0] sel_value [N],
	input  logic         hit [N],
	output logic [W-1:0] value,
	output logic         found
);
	import smtk_pkg::*;

	localparam int NG = (N + GRP_SIZE - 1) / GRP_SIZE;

	logic [W-1:0] grp_val_c [NG];
	logic         grp_hit_c [NG];
	logic [W-1:0] grp_val_s1 [NG];
	logic         grp_hit_s1 [NG];
	logic [W-1:0] val_c;
	logic         hit_c;
	logic [W-1:0] value_s2;
	logic         found_s2;

	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_val_c[g] = '0;
			grp_hit_c[g] = 1'b0;
			for (int e = 0; e < GRP_SIZE; e++) begin
				if (g * GRP_SIZE + e < N) begin
					grp_val_c[g] = grp_val_c[g] | sel_value[g * GRP_SIZE + e];
					grp_hit_c[g] = grp_hit_c[g] | hit[g * GRP_SIZE + e];
				end
			end
		end

		always_ff @(posedge clk) begin
			grp_val_s1[g] <= grp_val_c[g];
			grp_hit_s1[g] <= grp_hit_c[g];
		end
	end

	always_comb begin
		val_c = '0;
		hit_c = 1'b0;
		for (int g = 0; g < NG; g++) begin
			val_c = val_c | grp_val_s1[g];
			hit_c = hit_c | grp_hit_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		value_s2 <= val_c;
		found_s2 <= hit_c;
	end

	assign value = value_s2;
	assign found = found_s2;

endmodule

// File: rtl/core/sorted_multiset_top_k_sum.sv
// ----------------------------------------------------------------------------
// sorted_multiset_top_k_sum: ordered multiset with a running top-k value sum
// Chain of slots in descending order, a probe tree and the sum sequencer.
// ----------------------------------------------------------------------------
// An item is accepted on start while busy is low and its result comes back
// as a one-cycle done strobe after the probe, fetch and apply states, when
// busy also drops; a new start can be accepted in that done cycle. The probe
// and fetch states wait on the two-stage probe tree that reads the slot at the
// top_count boundary before the chain shifts. After a top_count write the next
// item first recounts the sum one slot per cycle through that tree. The result
// cannot be held off: sample result in the cycle done is high.
module sorted_multiset_top_k_sum #(
	parameter int CAPACITY   = smtk_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = smtk_pkg::VALUE_BITS_DEF,
	parameter int TAG_BITS   = smtk_pkg::TAG_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  smtk_pkg::smtk_cmd_t           cmd,
	output logic                          done,
	output smtk_pkg::smtk_result_t        result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smtk_pkg::APB_AW-1:0]   paddr,
	input  logic [smtk_pkg::APB_DW-1:0]   pwdata,
	output logic [smtk_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import smtk_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > TOPC_W) ? CNT_W : TOPC_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_PROBE = 5'b00100,
		ST_FETCH = 5'b01000,
		ST_APPLY = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;
	logic [TOPC_W-1:0]     top_count_q;
	logic                  dirty_q;
	logic [CMP_W-1:0]      probe_q;
	logic                  vld_s1;
	logic                  vld_s2;
	logic                  done_q;
	logic                  kind_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [TAG_BITS-1:0]   tag_q;
	smtk_result_t          result_q;

	logic                  accept;
	logic                  cfg_wr;
	logic [CMP_W-1:0]      c_ext;
	logic [CMP_W-1:0]      k_ext;
	logic [CMP_W-1:0]      take;
	logic [CMP_W-1:0]      probe_base;
	logic [CMP_W-1:0]      probe_new;
	logic [CMP_W-1:0]      probe_held;
	logic                  sweep_end;
	logic                  full;
	logic                  k_zero;
	logic [VALUE_BITS-1:0] probe_val;
	logic                  found;
	logic [SUM_W-1:0]      v_sum;
	logic [SUM_W-1:0]      pv_sum;
	logic [SUM_W-1:0]      sum_nxt;
	logic [CNT_W-1:0]      cnt_nxt;
	logic [STATUS_W-1:0]   status_nxt;
	smtk_cell_ctl_t        cell_ctl;

	logic [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic [TAG_BITS-1:0]   cell_tag [CAPACITY];
	logic                  cell_gt [CAPACITY];
	logic                  cell_eq [CAPACITY];
	logic [VALUE_BITS-1:0] cell_pv [CAPACITY];

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_TOP_COUNT) ? APB_DW'(top_count_q) : '0;

	assign c_ext      = CMP_W'(count_q);
	assign k_ext      = CMP_W'(top_count_q);
	assign take       = (k_ext < c_ext) ? k_ext : c_ext;
	assign probe_base = k_ext - CMP_W'(1);
	assign probe_new  = probe_base + CMP_W'(cmd.kind);
	assign probe_held = probe_base + CMP_W'(kind_q);
	assign sweep_end  = (probe_q >= take) && !vld_s1 && !vld_s2;
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign k_zero     = (top_count_q == '0);
	assign v_sum      = SUM_W'(val_q);
	assign pv_sum     = SUM_W'(probe_val);

	assign cell_ctl.load_ins = (state_q == ST_APPLY) && (kind_q == KIND_INSERT) && !full;
	assign cell_ctl.load_ers = (state_q == ST_APPLY) && (kind_q == KIND_ERASE) && found;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] lft_val;
		logic [TAG_BITS-1:0]   lft_tag;
		logic                  lft_gt;
		logic [VALUE_BITS-1:0] rgt_val;
		logic [TAG_BITS-1:0]   rgt_tag;

		if (i == 0) begin : g_head
			assign lft_val = '0;
			assign lft_tag = '0;
			assign lft_gt  = 1'b1;
		end else begin : g_mid
			assign lft_val = cell_val[i-1];
			assign lft_tag = cell_tag[i-1];
			assign lft_gt  = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rgt_val = cell_val[i];
			assign rgt_tag = cell_tag[i];
		end else begin : g_body
			assign rgt_val = cell_val[i+1];
			assign rgt_tag = cell_tag[i+1];
		end

		smtk_cell #(
			.VALUE_BITS (VALUE_BITS),
			.TAG_BITS   (TAG_BITS),
			.CMP_W      (CMP_W),
			.IDX        (i)
		) u_cell (
			.clk         (clk),
			.ctl         (cell_ctl),
			.op_value    (val_q),
			.op_tag      (tag_q),
			.count       (c_ext),
			.probe       (probe_q),
			.left_value  (lft_val),
			.left_tag    (lft_tag),
			.left_gt     (lft_gt),
			.right_value (rgt_val),
			.right_tag   (rgt_tag),
			.value       (cell_val[i]),
			.tag         (cell_tag[i]),
			.gt          (cell_gt[i]),
			.eq          (cell_eq[i]),
			.probe_value (cell_pv[i])
		);
	end

	smtk_probe_tree #(
		.N (CAPACITY),
		.W (VALUE_BITS)
	) u_probe_tree (
		.clk       (clk),
		.sel_value (cell_pv),
		.hit       (cell_eq),
		.value     (probe_val),
		.found     (found)
	);

	always_comb begin
		sum_nxt    = sum_q;
		cnt_nxt    = count_q;
		status_nxt = STATUS_DONE;
		if (kind_q == KIND_INSERT) begin
			if (full) begin
				status_nxt = STATUS_FULL;
			end else begin
				cnt_nxt = count_q + CNT_W'(1);
				if (!k_zero) begin
					if (c_ext < k_ext) begin
						sum_nxt = sum_q + v_sum;
					end else if (probe_val <= val_q) begin
						sum_nxt = sum_q + v_sum - pv_sum;
					end
				end
			end
		end else begin
			if (!found) begin
				status_nxt = STATUS_NOT_FOUND;
			end else begin
				cnt_nxt = count_q - CNT_W'(1);
				if (!k_zero) begin
					if (c_ext <= k_ext) begin
						sum_nxt = sum_q - v_sum;
					end else if (probe_val < val_q) begin
						sum_nxt = sum_q + pv_sum - v_sum;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			top_count_q <= TOP_COUNT_RST;
			dirty_q     <= 1'b0;
			probe_q     <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_SWEEP) && (probe_q < take);
			vld_s2 <= vld_s1;
			if (cfg_wr && (paddr[APB_AW-1:2] == REG_TOP_COUNT)) begin
				top_count_q <= pwdata[TOPC_W-1:0];
				dirty_q     <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (dirty_q) begin
							state_q <= ST_SWEEP;
							probe_q <= '0;
							sum_q   <= '0;
						end else begin
							state_q <= ST_PROBE;
							probe_q <= probe_new;
						end
					end
				end
				ST_SWEEP: begin
					if (vld_s2) begin
						sum_q <= sum_q + pv_sum;
					end
					if (sweep_end) begin
						state_q <= ST_PROBE;
						probe_q <= probe_held;
						dirty_q <= 1'b0;
					end else if (probe_q < take) begin
						probe_q <= probe_q + CMP_W'(1);
					end
				end
				ST_PROBE: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					count_q <= cnt_nxt;
					sum_q   <= sum_nxt;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			val_q  <= VALUE_BITS'(cmd.entry_value);
			tag_q  <= TAG_BITS'(cmd.entry_tag);
		end
		if (state_q == ST_APPLY) begin
			result_q.top_sum     <= sum_nxt;
			result_q.entry_count <= TOPC_W'(cnt_nxt);
			result_q.status      <= status_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_APPLY))
		else $error("done without a preceding apply cycle");

	a_idle_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result beat is shown");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_APPLY) |=> $stable(count_q))
		else $error("entry count moved outside apply");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STATUS_FULL)) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full status with free slots");
`endif

endmodule
